// ----- rtl/guest_buffer_region_translator_macros.svh -----
// assertion macros used by the region translator sequencer, gbrt_ctrl
// no dependencies; included by the files that carry checks
`ifndef GUEST_BUFFER_REGION_TRANSLATOR_MACROS_SVH
`define GUEST_BUFFER_REGION_TRANSLATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GBRT_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbrt check failed");

// next-cycle implication, disabled while reset is low
`define GBRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbrt check failed");

`endif

// ----- rtl/gbrt_pkg.sv -----
// shared constants, types and codes for the region translator
// no dependencies
package gbrt_pkg;

    localparam int NUM_ZONES        = 4;
    localparam int REGIONS_PER_ZONE = 4;
    localparam int TABLE_DEPTH      = NUM_ZONES * REGIONS_PER_ZONE;

    // fixed field widths
    localparam int ACTION_W = 1;
    localparam int ZONE_W   = 2;
    localparam int SLOT_W   = 2;
    localparam int ADDR_W   = 64;
    localparam int CNT_W    = 3;
    localparam int STATUS_W = 2;

    // derived widths
    localparam int ZONE_IDX_W   = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int REGION_IDX_W = (REGIONS_PER_ZONE > 1) ? $clog2(REGIONS_PER_ZONE) : 1;
    localparam int LIVE_W       = $clog2(REGIONS_PER_ZONE + 1);
    localparam int TABLE_AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [ACTION_W-1:0] ACTION_TRANSLATE = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_WRITE     = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd2;

    // table entry as stored: end and host offset are worked out on the write
    typedef struct packed {
        logic [ADDR_W-1:0] delta;   // host base minus guest base, wrapping
        logic [ADDR_W-1:0] limit;   // guest base plus size, wrapping
        logic [ADDR_W-1:0] base;
    } region_entry_t;

    typedef struct packed {
        logic                    capture;
        logic                    write;
        logic                    rd_en;
        logic [REGION_IDX_W-1:0] rd_idx;
        logic                    eval;
        logic                    load;
    } dp_cmd_t;

    typedef struct packed {
        logic              is_write;
        logic [LIVE_W-1:0] live_count;
    } dp_status_t;

endpackage

// ----- rtl/guest_buffer_region_translator.sv -----
// channel  | direction | handshake          | carries
// s_       | in        | s_valid / s_ready  | translate request or region table write
// m_       | out       | m_valid / m_ready  | host address, length, status, range flag
// cfg_     | in        | cfg_wr_en          | check_range mode bit
//
// a translate request has its result registered once the live regions of its zone are scanned:
// the region table ram is read one entry per cycle
// a write request writes its table entry in the scan state, then has its result registered
// the next request is taken the cycle after the result loads
// reset clears the zone counts and sets checking mode; region entries hold nothing until written
// a result waiting on m_ready does not block acceptance of the next request
// top level: wires the sequencer to the datapath; depends on gbrt_pkg, gbrt_ctrl, gbrt_dp
module guest_buffer_region_translator
    import gbrt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ZONE_W-1:0]   s_zone,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [ADDR_W-1:0]   s_guest_addr,
    input  logic [ADDR_W-1:0]   s_length,
    input  logic [ADDR_W-1:0]   s_host_origin,
    input  logic [CNT_W-1:0]    s_region_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_host_addr,
    output logic [ADDR_W-1:0]   m_out_length,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_range_ok
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gbrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gbrt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_action       (s_action),
        .s_zone         (s_zone),
        .s_slot         (s_slot),
        .s_guest_addr   (s_guest_addr),
        .s_length       (s_length),
        .s_host_origin  (s_host_origin),
        .s_region_count (s_region_count),
        .cmd            (cmd),
        .status         (status),
        .m_host_addr    (m_host_addr),
        .m_out_length   (m_out_length),
        .m_status       (m_status),
        .m_range_ok     (m_range_ok)
    );

endmodule

// ----- rtl/gbrt_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module gbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/gbrt_ctrl.sv -----
// sequencer for the region translator: capture, table scan, result hand-off
// depends on gbrt_pkg and the assertion macros
`include "guest_buffer_region_translator_macros.svh"

module gbrt_ctrl
    import gbrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [LIVE_W-1:0] idx_reg, idx_next;
    logic              eval_pending_reg, eval_pending_next;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        eval_pending_next = 1'b0;
        m_valid_next      = m_valid_reg;
        cmd               = '0;
        cmd.rd_idx        = idx_reg[REGION_IDX_W-1:0];
        cmd.eval          = eval_pending_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.is_write) begin
                    cmd.write  = 1'b1;
                    state_next = ST_DONE;
                end else if (idx_reg != status.live_count) begin
                    // one region read per cycle, checked the cycle after
                    cmd.rd_en         = 1'b1;
                    idx_next          = idx_reg + LIVE_W'(1);
                    eval_pending_next = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            eval_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            eval_pending_reg <= eval_pending_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `GBRT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    `GBRT_ASSERT_HOLDS(a_scan_in_bounds, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= status.live_count)
    `GBRT_ASSERT_HOLDS(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_DONE))

endmodule

// ----- rtl/gbrt_dp.sv -----
// datapath: request capture, zone counts, region table, compare and result registers
// depends on gbrt_pkg and gbrt_ram
module gbrt_dp
    import gbrt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ZONE_W-1:0]   s_zone,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [ADDR_W-1:0]   s_guest_addr,
    input  logic [ADDR_W-1:0]   s_length,
    input  logic [ADDR_W-1:0]   s_host_origin,
    input  logic [CNT_W-1:0]    s_region_count,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic [ADDR_W-1:0]   m_host_addr,
    output logic [ADDR_W-1:0]   m_out_length,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_range_ok
);

    logic                check_range_reg;
    logic [LIVE_W-1:0]   count_reg [NUM_ZONES];

    // captured request
    logic [ACTION_W-1:0] action_reg;
    logic [ZONE_W-1:0]   zone_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   len_reg;
    logic [ADDR_W-1:0]   hbase_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ADDR_W-1:0]   end_reg;
    logic                ovf_reg;

    // scan accumulators
    logic                inside_reg;
    logic                mapped_reg;
    logic [ADDR_W-1:0]   host_acc_reg;

    // result registers
    logic [ADDR_W-1:0]   host_out_reg;
    logic [ADDR_W-1:0]   len_out_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic                rok_out_reg;

    logic [ADDR_W:0]         end_sum;
    logic [ZONE_IDX_W-1:0]   zone_idx;
    logic                    zone_ok;
    logic                    slot_ok;
    logic [LIVE_W-1:0]       cnt_sat;
    logic [TABLE_AW-1:0]     zone_row;
    logic [TABLE_AW-1:0]     wr_addr;
    logic [TABLE_AW-1:0]     rd_addr;
    region_entry_t           wr_entry;
    region_entry_t           rd_entry;
    logic [$bits(region_entry_t)-1:0] rd_word;
    logic                    hit_base;
    logic                    hit_range;

    assign end_sum  = {1'b0, s_guest_addr} + {1'b0, s_length};
    assign zone_idx = ZONE_IDX_W'(zone_reg);
    assign zone_ok  = int'(zone_reg) < NUM_ZONES;
    assign slot_ok  = int'(slot_reg) < REGIONS_PER_ZONE;
    assign cnt_sat  = (int'(cnt_reg) > REGIONS_PER_ZONE) ? LIVE_W'(REGIONS_PER_ZONE)
                                                         : LIVE_W'(cnt_reg);

    assign status.is_write   = (action_reg == ACTION_WRITE);
    assign status.live_count = zone_ok ? count_reg[zone_idx] : '0;

    assign zone_row = TABLE_AW'(zone_idx) * TABLE_AW'(REGIONS_PER_ZONE);
    assign wr_addr  = zone_row + TABLE_AW'(slot_reg);
    assign rd_addr  = zone_row + TABLE_AW'(cmd.rd_idx);

    assign wr_entry.base  = addr_reg;
    assign wr_entry.limit = addr_reg + len_reg;
    assign wr_entry.delta = hbase_reg - addr_reg;

    gbrt_ram #(
        .WIDTH ($bits(region_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.write && zone_ok && slot_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry  = region_entry_t'(rd_word);
    assign hit_base  = (rd_entry.base <= addr_reg) && (addr_reg < rd_entry.limit);
    assign hit_range = !ovf_reg && (addr_reg >= rd_entry.base) && (end_reg <= rd_entry.limit);

    // control state: mode register and zone counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_range_reg <= 1'b1;
            for (int z = 0; z < NUM_ZONES; z++) begin
                count_reg[z] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                check_range_reg <= cfg_wr_data;
            end
            if (cmd.write && zone_ok) begin
                count_reg[zone_idx] <= cnt_sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg   <= s_action;
            zone_reg     <= s_zone;
            slot_reg     <= s_slot;
            addr_reg     <= s_guest_addr;
            len_reg      <= s_length;
            hbase_reg    <= s_host_origin;
            cnt_reg      <= s_region_count;
            end_reg      <= end_sum[ADDR_W-1:0];
            ovf_reg      <= end_sum[ADDR_W];
            inside_reg   <= (s_length == '0);
            mapped_reg   <= 1'b0;
        end else if (cmd.eval) begin
            inside_reg <= inside_reg | hit_range;
            // first region holding the base wins
            if (!mapped_reg && hit_base) begin
                mapped_reg   <= 1'b1;
                host_acc_reg <= addr_reg + rd_entry.delta;
            end
        end

        if (cmd.load) begin
            if (status.is_write) begin
                host_out_reg   <= '0;
                len_out_reg    <= '0;
                status_out_reg <= STATUS_OK;
                rok_out_reg    <= 1'b0;
            end else begin
                rok_out_reg <= inside_reg;
                if (check_range_reg) begin
                    if (!inside_reg) begin
                        host_out_reg   <= '0;
                        len_out_reg    <= '0;
                        status_out_reg <= STATUS_RANGE;
                    end else if (!mapped_reg) begin
                        host_out_reg   <= '0;
                        len_out_reg    <= '0;
                        status_out_reg <= STATUS_UNMAPPED;
                    end else begin
                        host_out_reg   <= host_acc_reg;
                        len_out_reg    <= len_reg;
                        status_out_reg <= STATUS_OK;
                    end
                end else begin
                    host_out_reg   <= mapped_reg ? host_acc_reg : '0;
                    len_out_reg    <= len_reg;
                    status_out_reg <= STATUS_OK;
                end
            end
        end
    end

    assign m_host_addr  = host_out_reg;
    assign m_out_length = len_out_reg;
    assign m_status     = status_out_reg;
    assign m_range_ok   = rok_out_reg;

endmodule

// ----- test/testbench.sv -----
// self-checking bench for guest_buffer_region_translator: directed table, then random requests
// predicts untyped results from its own copy of the region tables and mode bit
// depends on gbrt_pkg and the guest_buffer_region_translator rtl
`timescale 1ns / 1ps

module testbench;
    import gbrt_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 8;
    localparam int REPORT_LINES    = 40;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [ZONE_W-1:0]   zone;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   guest_addr;
        logic [ADDR_W-1:0]   length;
        logic [ADDR_W-1:0]   host_origin;
        logic [CNT_W-1:0]    region_count;
    } buf_req_t;

    typedef struct {
        logic [ADDR_W-1:0]   host_addr;
        logic [ADDR_W-1:0]   out_length;
        logic [STATUS_W-1:0] status;
        logic                range_ok;
    } xlate_res_t;

    typedef struct {
        bit         mode;
        buf_req_t   req;
        bit         typed;
        xlate_res_t res;
    } directed_step_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action;
    logic [ZONE_W-1:0]   s_zone;
    logic [SLOT_W-1:0]   s_slot;
    logic [ADDR_W-1:0]   s_guest_addr;
    logic [ADDR_W-1:0]   s_length;
    logic [ADDR_W-1:0]   s_host_origin;
    logic [CNT_W-1:0]    s_region_count;
    logic                m_valid;
    logic                m_ready;
    logic [ADDR_W-1:0]   m_host_addr;
    logic [ADDR_W-1:0]   m_out_length;
    logic [STATUS_W-1:0] m_status;
    logic                m_range_ok;

    // predictor copy of the block state
    logic [ADDR_W-1:0] region_base [TABLE_DEPTH];
    logic [ADDR_W-1:0] region_host [TABLE_DEPTH];
    logic [ADDR_W-1:0] region_len  [TABLE_DEPTH];
    bit                region_loaded [TABLE_DEPTH];
    int unsigned       zone_live [NUM_ZONES];
    bit                range_checking = 1'b1;

    xlate_res_t     pending_results [$];
    directed_step_t directed_steps [$];
    xlate_res_t     row_expect;
    bit             row_typed = 1'b0;
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    guest_buffer_region_translator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_zone         (s_zone),
        .s_slot         (s_slot),
        .s_guest_addr   (s_guest_addr),
        .s_length       (s_length),
        .s_host_origin  (s_host_origin),
        .s_region_count (s_region_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_host_addr    (m_host_addr),
        .m_out_length   (m_out_length),
        .m_status       (m_status),
        .m_range_ok     (m_range_ok)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic buf_req_t mk_req(logic [ACTION_W-1:0] action, logic [ZONE_W-1:0] zone,
                                        logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] guest_addr,
                                        logic [ADDR_W-1:0] length, logic [ADDR_W-1:0] host_origin,
                                        logic [CNT_W-1:0] region_count);
        buf_req_t r;
        r.action       = action;
        r.zone         = zone;
        r.slot         = slot;
        r.guest_addr   = guest_addr;
        r.length       = length;
        r.host_origin  = host_origin;
        r.region_count = region_count;
        return r;
    endfunction

    function automatic xlate_res_t mk_res(logic [ADDR_W-1:0] host_addr,
                                          logic [ADDR_W-1:0] out_length,
                                          logic [STATUS_W-1:0] status, logic range_ok);
        xlate_res_t o;
        o.host_addr  = host_addr;
        o.out_length = out_length;
        o.status     = status;
        o.range_ok   = range_ok;
        return o;
    endfunction

    // updates the tables on a write, works out the translation otherwise
    function automatic xlate_res_t apply_request(input buf_req_t r);
        xlate_res_t        o;
        int unsigned       e;
        int unsigned       live;
        logic [ADDR_W:0]   span_end;
        logic [ADDR_W-1:0] region_end;
        logic [ADDR_W-1:0] xlated;
        bit                fits;
        bit                hit;
        o = mk_res('0, '0, STATUS_OK, 1'b0);
        if (r.action == ACTION_WRITE) begin
            e = r.zone * REGIONS_PER_ZONE + r.slot;
            region_base[e]   = r.guest_addr;
            region_len[e]    = r.length;
            region_host[e]   = r.host_origin;
            region_loaded[e] = 1'b1;
            zone_live[r.zone] = (r.region_count > REGIONS_PER_ZONE) ?
                                REGIONS_PER_ZONE : r.region_count;
            return o;
        end
        live     = zone_live[r.zone];
        span_end = {1'b0, r.guest_addr} + {1'b0, r.length};
        fits     = (r.length == '0);
        hit      = 1'b0;
        xlated   = '0;
        for (int i = 0; i < live; i++) begin
            e          = r.zone * REGIONS_PER_ZONE + i;
            region_end = region_base[e] + region_len[e];
            // a range whose end carries out of 64 bits never fits
            if (!fits && !span_end[ADDR_W] && r.guest_addr >= region_base[e] &&
                span_end[ADDR_W-1:0] <= region_end)
                fits = 1'b1;
            if (!hit && region_base[e] <= r.guest_addr && r.guest_addr < region_end) begin
                hit    = 1'b1;
                xlated = r.guest_addr - region_base[e] + region_host[e];
            end
        end
        o.range_ok = fits;
        if (range_checking) begin
            if (!fits)
                o.status = STATUS_RANGE;
            else if (!hit)
                o.status = STATUS_UNMAPPED;
            else begin
                o.host_addr  = xlated;
                o.out_length = r.length;
            end
        end else begin
            o.host_addr  = hit ? xlated : '0;
            o.out_length = r.length;
        end
        return o;
    endfunction

    // mostly requests aimed at live regions; never makes a live entry that was not loaded
    function automatic buf_req_t random_request();
        buf_req_t          r;
        int unsigned       e;
        int unsigned       live;
        int unsigned       prefix;
        int unsigned       wanted;
        logic [ADDR_W-1:0] sz;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] span;
        r = mk_req(($urandom_range(0, 99) < 22) ? ACTION_WRITE : ACTION_TRANSLATE,
                   ZONE_W'($urandom_range(0, NUM_ZONES - 1)),
                   SLOT_W'($urandom_range(0, REGIONS_PER_ZONE - 1)),
                   rand64(), rand64(), rand64(), CNT_W'($urandom_range(0, 7)));
        if (r.action == ACTION_WRITE) begin
            // fill holes first so zones soon carry their full table
            if ($urandom_range(0, 1) == 0) begin
                for (int i = REGIONS_PER_ZONE - 1; i >= 0; i--)
                    if (!region_loaded[r.zone * REGIONS_PER_ZONE + i])
                        r.slot = SLOT_W'(i);
            end
            case ($urandom_range(0, 9)) inside
                [0:4]:   r.length = ADDR_W'($urandom_range(1, 65536));
                [5:7]:   r.length = rand64() >> $urandom_range(0, 63);
                8:       r.length = rand64();
                default: r.length = '0;
            endcase
            if ($urandom_range(0, 1) == 0)
                r.guest_addr = ADDR_W'($urandom);
            prefix = 0;
            while (prefix < REGIONS_PER_ZONE &&
                   (region_loaded[r.zone * REGIONS_PER_ZONE + prefix] || prefix == r.slot))
                prefix++;
            wanted = (r.region_count > REGIONS_PER_ZONE) ? REGIONS_PER_ZONE : r.region_count;
            if (wanted > prefix)
                r.region_count = ($urandom_range(0, 3) != 0) ? CNT_W'(prefix)
                                                             : CNT_W'($urandom_range(0, prefix));
            return r;
        end
        live = zone_live[r.zone];
        if (live > 0 && $urandom_range(0, 99) < 75) begin
            e  = r.zone * REGIONS_PER_ZONE + $urandom_range(0, live - 1);
            sz = region_len[e];
            case ($urandom_range(0, 3))
                0:       off = '0;
                1:       off = (sz == '0) ? '0 : sz - 1;
                default: off = (sz == '0) ? '0 : rand64() % sz;
            endcase
            r.guest_addr = region_base[e] + off;
            span         = sz - off;
            case ($urandom_range(0, 5))
                0: r.length = '0;
                1: r.length = span;
                2: r.length = span + 1;
                3: r.length = ADDR_W'($urandom_range(1, 64));
                4: if (span + 1 != '0) r.length = rand64() % (span + 1);
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("%0t: %s", $time, what);
    endtask

    always @(posedge aclk) begin : scoreboard
        xlate_res_t got;
        xlate_res_t want;
        xlate_res_t predicted;
        buf_req_t   taken;
        if (aresetn && m_valid && m_ready) begin
            got = mk_res(m_host_addr, m_out_length, m_status, m_range_ok);
            if (pending_results.size() == 0) begin
                flag_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got.host_addr !== want.host_addr)
                    flag_mismatch($sformatf("host_addr %h, expected %h",
                                            got.host_addr, want.host_addr));
                if (got.out_length !== want.out_length)
                    flag_mismatch($sformatf("out_length %h, expected %h",
                                            got.out_length, want.out_length));
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
                if (got.range_ok !== want.range_ok)
                    flag_mismatch($sformatf("range_ok %0b, expected %0b",
                                            got.range_ok, want.range_ok));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            taken = mk_req(s_action, s_zone, s_slot, s_guest_addr, s_length, s_host_origin,
                           s_region_count);
            predicted = apply_request(taken);
            pending_results.push_back(row_typed ? row_expect : predicted);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // holds the request until it is taken, then returns at the next falling edge
    task automatic send_request(input buf_req_t r, input bit typed, input xlate_res_t e);
        s_action       = r.action;
        s_zone         = r.zone;
        s_slot         = r.slot;
        s_guest_addr   = r.guest_addr;
        s_length       = r.length;
        s_host_origin  = r.host_origin;
        s_region_count = r.region_count;
        row_typed      = typed;
        row_expect     = e;
        s_valid        = 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_mode(input bit mode);
        drain();
        cfg_wr_data = mode;
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en      = 1'b0;
        range_checking = mode;
    endtask

    task automatic set_idle(input int profile);
        case (profile)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    task automatic add_step(input bit mode, input buf_req_t r, input bit typed,
                            input xlate_res_t e);
        directed_step_t st;
        st.mode  = mode;
        st.req   = r;
        st.typed = typed;
        st.res   = e;
        directed_steps.push_back(st);
    endtask

    initial begin
        xlate_res_t none;
        bit         mode;
        none           = mk_res('0, '0, STATUS_OK, 1'b0);
        row_expect     = none;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACTION_TRANSLATE;
        s_zone         = '0;
        s_slot         = '0;
        s_guest_addr   = '0;
        s_length       = '0;
        s_host_origin  = '0;
        s_region_count = '0;

        // checking mode, straight out of reset: no zone has a live region
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, '0, '0, '0, 0), 1,
                 mk_res('0, '0, STATUS_UNMAPPED, 1'b1));
        add_step(1, mk_req(ACTION_TRANSLATE, 3, 0, '1, '1, '0, 0), 1,
                 mk_res('0, '0, STATUS_RANGE, 1'b0));
        add_step(1, mk_req(ACTION_TRANSLATE, 1, 0, '1, '0, '1, 7), 1,
                 mk_res('0, '0, STATUS_UNMAPPED, 1'b1));
        add_step(1, mk_req(ACTION_WRITE, 0, 0, 64'h1000, 64'h1000, 64'h8000_0000, 1), 1, none);
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'h1000, 64'h1000, '0, 0), 1,
                 mk_res(64'h8000_0000, 64'h1000, STATUS_OK, 1'b1));
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'h1fff, 64'h2, '0, 0), 0, none);
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'hfff, '0, '0, 0), 0, none);
        // region whose end wraps to zero
        add_step(1, mk_req(ACTION_WRITE, 0, 1, 64'hffff_ffff_ffff_f000, 64'h1000, '1, 2), 1,
                 none);
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'hffff_ffff_ffff_f800, 64'h10, '0, 0), 0,
                 none);
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'hffff_ffff_ffff_f800, 64'h800, '0, 0), 0,
                 none);
        add_step(1, mk_req(ACTION_WRITE, 0, 2, '0, '1, 64'h1234, 3), 1, none);
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'hffff_ffff_ffff_fffe, 64'h1, '0, 0), 0,
                 none);
        // count above the table saturates
        add_step(1, mk_req(ACTION_WRITE, 0, 3, 64'h2000, '0, 64'h5, 7), 1, none);
        add_step(1, mk_req(ACTION_TRANSLATE, 0, 0, 64'h2000, '0, '0, 0), 0, none);
        add_step(1, mk_req(ACTION_WRITE, 1, 0, 64'h10, 64'h10, '1, 1), 1, none);
        add_step(1, mk_req(ACTION_WRITE, 2, 0, '0, 64'h100, '0, 0), 1, none);
        add_step(1, mk_req(ACTION_TRANSLATE, 1, 0, 64'h1f, 64'h1, '0, 0), 0, none);
        add_step(1, mk_req(ACTION_TRANSLATE, 2, 0, 64'h10, 64'h4, '0, 0), 0, none);
        add_step(1, mk_req(ACTION_WRITE, 3, 3, 64'h40, 64'h40, 64'h100, 0), 1, none);
        // baseline mode
        add_step(0, mk_req(ACTION_TRANSLATE, 0, 0, 64'h1fff, 64'h2, '0, 0), 0, none);
        add_step(0, mk_req(ACTION_TRANSLATE, 0, 0, 64'hffff_ffff_ffff_f800, '1, '0, 0), 0,
                 none);
        add_step(0, mk_req(ACTION_TRANSLATE, 2, 0, '0, 64'h10, '0, 0), 0, none);
        add_step(0, mk_req(ACTION_TRANSLATE, 0, 0, '1, '0, '0, 0), 0, none);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_idle(0);
        foreach (directed_steps[k]) begin
            if (directed_steps[k].mode != range_checking)
                set_mode(directed_steps[k].mode);
            send_request(directed_steps[k].req, directed_steps[k].typed, directed_steps[k].res);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mode = (phase >= NUM_PHASES / 2);
            if (mode != range_checking)
                set_mode(mode);
            set_idle(phase % 4);
            repeat (ITEMS_PER_PHASE) begin
                // now and then hold back until every outstanding request has answered
                if ($urandom_range(0, 149) == 0)
                    drain();
                sender_gap();
                send_request(random_request(), 1'b0, none);
            end
        end

        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- guest_buffer_region_translator.f -----
+incdir+rtl
rtl/gbrt_pkg.sv
rtl/gbrt_ram.sv
rtl/gbrt_ctrl.sv
rtl/gbrt_dp.sv
rtl/guest_buffer_region_translator.sv
test/testbench.sv
